/* hw/rtl/srqe_pkg.sv */
// Shared types, constants and helpers of the segment ribbon quad expander.
`timescale 1ns / 1ps
`default_nettype none

package srqe_pkg;

  localparam int unsigned MAX_SEGMENTS = 512;
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned VN_W         = 11;

  localparam logic [2:0] CFG_CAMERA_X   = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y   = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z   = 3'd2;
  localparam logic [2:0] CFG_HALF_WIDTH = 3'd3;
  localparam logic [2:0] CFG_MIN_LENGTH = 3'd4;

  localparam logic       OP_FINISH    = 1'b1;
  localparam logic       KIND_VERTEX  = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;
  localparam logic [2:0] COLOR_BLUE   = 3'd0;
  localparam logic [2:0] COLOR_RED    = 3'd2;
  localparam logic [2:0] COLOR_LAST   = 3'd4;

  localparam logic [31:0] HALF_WIDTH_RST = 32'd49152;
  localparam logic [15:0] MIN_LENGTH_RST = 16'd1;

  typedef struct packed {
    logic [31:0] camera_x;
    logic [31:0] camera_y;
    logic [31:0] camera_z;
    logic [31:0] half_width;
    logic [15:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic        finish;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic [2:0]  pal;
  } item_t;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (33'd0 - v) : v;
  endfunction

  function automatic logic [32:0] mag32(input logic [31:0] v);
    return v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic [41:0] mag42(input logic [41:0] v);
    return v[41] ? (42'd0 - v) : v;
  endfunction

  // clamp a 43-bit two's complement value into 32 bits
  function automatic logic [31:0] sat32(input logic [42:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (!v[42] && (|v[41:31])) r = 32'h7FFF_FFFF;
    if (v[42] && !(&v[41:31])) r = 32'h8000_0000;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srqe_front.sv */
// Front end: accepts words, picks the final color and queues them.
`timescale 1ns / 1ps
`default_nettype none

module srqe_front import srqe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] start_x_i,
  input  logic [31:0] start_y_i,
  input  logic [31:0] start_z_i,
  input  logic [31:0] end_x_i,
  input  logic [31:0] end_y_i,
  input  logic [31:0] end_z_i,
  input  logic [2:0]  color_code_i,
  input  logic        rejected_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item_in;
  logic        push;

  always_comb begin
    item_in.finish = (op_i == OP_FINISH);
    item_in.sx     = start_x_i;
    item_in.sy     = start_y_i;
    item_in.sz     = start_z_i;
    item_in.ex     = end_x_i;
    item_in.ey     = end_y_i;
    item_in.ez     = end_z_i;
    if (rejected_i) begin
      item_in.pal = COLOR_RED;
    end else if (color_code_i > COLOR_LAST) begin
      item_in.pal = COLOR_BLUE;
    end else begin
      item_in.pal = color_code_i;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (q_pop_i && q_valid_o) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srqe_sqrt.sv */
// Bit-pair integer square root of a 64-bit value, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module srqe_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] arg_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, x_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  assign trial  = {1'b0, r_q} + {1'b0, bit_q};
  assign done_o = done_q;
  assign root_o = r_q[31:0];

  always_comb begin
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = arg_i;
      r_d    = 64'd0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_d = x_q - trial[63:0];
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == 64'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/srqe_div.sv */
// Radix-2 restoring divider, 64-bit dividend by 33-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module srqe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  assign trial  = {rem_q, num_q[63]};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = 33'd0;
      cnt_d  = 6'd63;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 33'(trial - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/srqe_back.sv */
// Back end: sequences the vector math per segment and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module srqe_back import srqe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               sqrt_start_o,
  output logic [63:0]        sqrt_arg_o,
  input  logic               sqrt_done_i,
  input  logic [31:0]        sqrt_root_i,
  output logic               div_start_o,
  output logic [63:0]        div_num_o,
  output logic [32:0]        div_den_o,
  input  logic               div_done_i,
  input  logic [63:0]        div_quo_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic               tex_u_o,
  output logic [31:0]        tex_v_o,
  output logic [2:0]         palette_index_o,
  output logic [VN_W-1:0]    vertex_number_o,
  output logic [CNT_W-1:0]   segment_count_o,
  output logic               last_o
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_SQ     = 13'b0000000000010,
    ST_ROOT   = 13'b0000000000100,
    ST_LEN    = 13'b0000000001000,
    ST_UNIT   = 13'b0000000010000,
    ST_CR1    = 13'b0000000100000,
    ST_CR2    = 13'b0000001000000,
    ST_CR3    = 13'b0000010000000,
    ST_OFFM   = 13'b0000100000000,
    ST_OFFD   = 13'b0001000000000,
    ST_EMIT   = 13'b0010000000000,
    ST_AVG    = 13'b0100000000000,
    ST_SUMOUT = 13'b1000000000000
  } state_e;

  typedef enum logic [3:0] {
    PH_DIR  = 4'b0001,
    PH_VIEW = 4'b0010,
    PH_SIDE = 4'b0100,
    PH_FALL = 4'b1000
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [1:0]        idx_q, idx_d;
  logic              started_q, started_d;
  item_t             item_q, item_d;
  logic [31:0]       mid_q [3];
  logic [31:0]       mid_d [3];
  logic [32:0]       vec_q [3];
  logic [32:0]       vec_d [3];
  logic [31:0]       ud_q [3];
  logic [31:0]       ud_d [3];
  logic [31:0]       uv_q [3];
  logic [31:0]       uv_d [3];
  logic [41:0]       off_q [3];
  logic [41:0]       off_d [3];
  logic [41:0]       sum_q [3];
  logic [41:0]       sum_d [3];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [32:0]       len_q, len_d;
  logic [32:0]       dlen_q, dlen_d;
  logic [63:0]       acc_q, acc_d;
  logic [65:0]       prod_q;
  logic              prod_neg_q;

  logic              ov_q, ov_d;
  logic              kind_q, kind_d;
  logic [31:0]       px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic              tu_q, tu_d;
  logic [31:0]       tv_q, tv_d;
  logic [2:0]        pal_q, pal_d;
  logic [VN_W-1:0]   vn_q, vn_d;
  logic [CNT_W-1:0]  sc_q, sc_d;
  logic              last_q, last_d;

  logic [1:0]        vsel;
  logic [32:0]       vmag;
  logic [31:0]       a1, b1, a2, b2;
  logic [32:0]       mul_a, mul_b;
  logic              mul_neg;
  logic [63:0]       prod_s;
  logic [63:0]       diff;
  logic [32:0]       ssum [3];
  logic [32:0]       thr;
  logic              out_free;
  logic [30:0]       usat;
  logic [31:0]       uval;
  logic [40:0]       osat;
  logic [41:0]       oval;
  logic [31:0]       aval;
  logic [31:0]       vpos [3];
  logic [31:0]       vcoord [3];
  logic              vplus;

  assign vsel     = (idx_q == 2'd3) ? 2'd0 : idx_q;
  assign vmag     = mag33(vec_q[vsel]);
  assign thr      = {3'd0, cfg_i.min_length, 14'd0};
  assign out_free = !ov_q || out_ready_i;
  assign prod_s   = prod_neg_q ? (64'd0 - prod_q[63:0]) : prod_q[63:0];
  assign diff     = acc_q - prod_s;
  assign usat     = (div_quo_i > 64'h4000_0000) ? 31'h4000_0000 : div_quo_i[30:0];
  assign uval     = vec_q[vsel][32] ? (32'd0 - {1'b0, usat}) : {1'b0, usat};
  assign osat     = (div_quo_i > 64'h100_0000_0000) ? 41'h100_0000_0000 : div_quo_i[40:0];
  assign oval     = vec_q[vsel][32] ? (42'd0 - {1'b0, osat}) : {1'b0, osat};
  assign aval     = sum_q[vsel][41] ? (32'd0 - div_quo_i[31:0]) : div_quo_i[31:0];

  always_comb begin
    ssum[0] = {item_q.sx[31], item_q.sx} + {item_q.ex[31], item_q.ex};
    ssum[1] = {item_q.sy[31], item_q.sy} + {item_q.ey[31], item_q.ey};
    ssum[2] = {item_q.sz[31], item_q.sz} + {item_q.ez[31], item_q.ez};
  end

  // cross product operand pairs for the component in progress
  always_comb begin
    case (idx_q)
      2'd1: begin
        a1 = ud_q[2]; b1 = uv_q[0]; a2 = ud_q[0]; b2 = uv_q[2];
      end
      2'd2: begin
        a1 = ud_q[0]; b1 = uv_q[1]; a2 = ud_q[1]; b2 = uv_q[0];
      end
      default: begin
        a1 = ud_q[1]; b1 = uv_q[2]; a2 = ud_q[2]; b2 = uv_q[1];
      end
    endcase
  end

  always_comb begin
    mul_a   = vmag;
    mul_b   = vmag;
    mul_neg = 1'b0;
    if (state_q == ST_CR1) begin
      mul_a   = mag32(a1);
      mul_b   = mag32(b1);
      mul_neg = a1[31] ^ b1[31];
    end else if (state_q == ST_CR2) begin
      mul_a   = mag32(a2);
      mul_b   = mag32(b2);
      mul_neg = a2[31] ^ b2[31];
    end else if (state_q == ST_OFFM) begin
      mul_b = {1'b0, cfg_i.half_width};
    end
  end

  // vertex geometry: corners 1 and 2 add the offset, 0 and 3 subtract it
  always_comb begin
    vplus = (idx_q == 2'd1) || (idx_q == 2'd2);
    if (idx_q[1]) begin
      vcoord[0] = item_q.ex; vcoord[1] = item_q.ey; vcoord[2] = item_q.ez;
    end else begin
      vcoord[0] = item_q.sx; vcoord[1] = item_q.sy; vcoord[2] = item_q.sz;
    end
    for (int i = 0; i < 3; i++) begin
      if (vplus) begin
        vpos[i] = sat32({{11{vcoord[i][31]}}, vcoord[i]} + {off_q[i][41], off_q[i]});
      end else begin
        vpos[i] = sat32({{11{vcoord[i][31]}}, vcoord[i]} - {off_q[i][41], off_q[i]});
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    idx_d        = idx_q;
    started_d    = started_q;
    item_d       = item_q;
    mid_d        = mid_q;
    vec_d        = vec_q;
    ud_d         = ud_q;
    uv_d         = uv_q;
    off_d        = off_q;
    sum_d        = sum_q;
    count_d      = count_q;
    len_d        = len_q;
    dlen_d       = dlen_q;
    acc_d        = acc_q;
    q_pop_o      = 1'b0;
    sqrt_start_o = 1'b0;
    sqrt_arg_o   = acc_q;
    div_start_o  = 1'b0;
    div_num_o    = {1'b0, vmag, 30'd0};
    div_den_o    = len_q;
    ov_d         = ov_q && !out_ready_i;
    kind_d       = kind_q;
    px_d         = px_q;
    py_d         = py_q;
    pz_d         = pz_q;
    tu_d         = tu_q;
    tv_d         = tv_q;
    pal_d        = pal_q;
    vn_d         = vn_q;
    sc_d         = sc_q;
    last_d       = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          idx_d   = 2'd0;
          acc_d   = 64'd0;
          if (q_item_i.finish) begin
            if (count_q == '0) begin
              mid_d[0] = 32'd0;
              mid_d[1] = 32'd0;
              mid_d[2] = 32'd0;
              state_d  = ST_SUMOUT;
            end else begin
              state_d = ST_AVG;
            end
          end else if (count_q < CNT_W'(MAX_SEGMENTS)) begin
            vec_d[0] = {q_item_i.ex[31], q_item_i.ex} - {q_item_i.sx[31], q_item_i.sx};
            vec_d[1] = {q_item_i.ey[31], q_item_i.ey} - {q_item_i.sy[31], q_item_i.sy};
            vec_d[2] = {q_item_i.ez[31], q_item_i.ez} - {q_item_i.sz[31], q_item_i.sz};
            phase_d  = PH_DIR;
            state_d  = ST_SQ;
          end
        end
      end

      ST_SQ: begin
        // product of the previous component comes out of the product register
        if (idx_q != 2'd0) begin
          acc_d = acc_q + prod_q[65:2];
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_ROOT;
        end
      end

      ST_ROOT: begin
        if (!started_q) begin
          sqrt_start_o = 1'b1;
          started_d    = 1'b1;
        end else if (sqrt_done_i) begin
          started_d = 1'b0;
          len_d     = {sqrt_root_i, 1'b0};
          state_d   = ST_LEN;
        end
      end

      ST_LEN: begin
        idx_d = 2'd0;
        acc_d = 64'd0;
        unique case (phase_q)
          PH_DIR: begin
            if (len_q <= {17'd0, cfg_i.min_length}) begin
              state_d = ST_IDLE;
            end else begin
              dlen_d  = len_q;
              for (int i = 0; i < 3; i++) begin
                mid_d[i] = ssum[i][32:1];
              end
              state_d = ST_UNIT;
            end
          end
          PH_VIEW: begin
            if (len_q <= {17'd0, cfg_i.min_length}) begin
              uv_d[0] = 32'd0;
              uv_d[1] = 32'd0;
              uv_d[2] = 32'h4000_0000;
              state_d = ST_CR1;
            end else begin
              state_d = ST_UNIT;
            end
          end
          PH_SIDE: begin
            if (len_q <= thr) begin
              vec_d[0] = 33'd0 - {ud_q[1][31], ud_q[1]};
              vec_d[1] = {ud_q[0][31], ud_q[0]};
              vec_d[2] = 33'd0;
              phase_d  = PH_FALL;
              state_d  = ST_SQ;
            end else begin
              state_d = ST_OFFM;
            end
          end
          PH_FALL: begin
            state_d = (len_q <= thr) ? ST_IDLE : ST_OFFM;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_UNIT: begin
        if (!started_q) begin
          div_start_o = 1'b1;
          started_d   = 1'b1;
        end else if (div_done_i) begin
          started_d = 1'b0;
          if (phase_q == PH_DIR) begin
            ud_d[vsel] = uval;
          end else begin
            uv_d[vsel] = uval;
          end
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            idx_d = 2'd0;
            if (phase_q == PH_DIR) begin
              // view vector from the midpoint toward the camera
              vec_d[0] = {cfg_i.camera_x[31], cfg_i.camera_x} - {mid_q[0][31], mid_q[0]};
              vec_d[1] = {cfg_i.camera_y[31], cfg_i.camera_y} - {mid_q[1][31], mid_q[1]};
              vec_d[2] = {cfg_i.camera_z[31], cfg_i.camera_z} - {mid_q[2][31], mid_q[2]};
              phase_d  = PH_VIEW;
              acc_d    = 64'd0;
              state_d  = ST_SQ;
            end else begin
              state_d = ST_CR1;
            end
          end
        end
      end

      ST_CR1: begin
        state_d = ST_CR2;
      end

      ST_CR2: begin
        acc_d   = prod_s;
        state_d = ST_CR3;
      end

      ST_CR3: begin
        vec_d[vsel] = diff[62:30];
        idx_d       = idx_q + 2'd1;
        state_d     = ST_CR1;
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          acc_d   = 64'd0;
          phase_d = PH_SIDE;
          state_d = ST_SQ;
        end
      end

      ST_OFFM: begin
        state_d = ST_OFFD;
      end

      ST_OFFD: begin
        div_num_o = prod_q[63:0];
        if (!started_q) begin
          div_start_o = 1'b1;
          started_d   = 1'b1;
        end else if (div_done_i) begin
          started_d   = 1'b0;
          off_d[vsel] = oval;
          idx_d       = idx_q + 2'd1;
          state_d     = ST_OFFM;
          if (idx_q == 2'd2) begin
            idx_d   = 2'd0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          kind_d = KIND_VERTEX;
          px_d   = vpos[0];
          py_d   = vpos[1];
          pz_d   = vpos[2];
          tu_d   = vplus;
          tv_d   = idx_q[1] ? {3'd0, dlen_q[32:4]} : 32'd0;
          pal_d  = item_q.pal;
          vn_d   = VN_W'({count_q, idx_q});
          sc_d   = '0;
          last_d = (idx_q == 2'd3);
          idx_d  = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            for (int i = 0; i < 3; i++) begin
              sum_d[i] = sum_q[i] + {{10{mid_q[i][31]}}, mid_q[i]};
            end
            count_d = count_q + CNT_W'(1);
            state_d = ST_IDLE;
          end
        end
      end

      ST_AVG: begin
        div_num_o = {22'd0, mag42(sum_q[vsel])};
        div_den_o = 33'(count_q);
        if (!started_q) begin
          div_start_o = 1'b1;
          started_d   = 1'b1;
        end else if (div_done_i) begin
          started_d   = 1'b0;
          mid_d[vsel] = aval;
          idx_d       = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            state_d = ST_SUMOUT;
          end
        end
      end

      ST_SUMOUT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          kind_d   = KIND_SUMMARY;
          px_d     = mid_q[0];
          py_d     = mid_q[1];
          pz_d     = mid_q[2];
          tu_d     = 1'b0;
          tv_d     = 32'd0;
          pal_d    = COLOR_BLUE;
          vn_d     = '0;
          sc_d     = count_q;
          last_d   = 1'b1;
          sum_d[0] = 42'd0;
          sum_d[1] = 42'd0;
          sum_d[2] = 42'd0;
          count_d  = '0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_DIR;
      idx_q     <= 2'd0;
      started_q <= 1'b0;
      count_q   <= '0;
      sum_q[0]  <= 42'd0;
      sum_q[1]  <= 42'd0;
      sum_q[2]  <= 42'd0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      started_q <= started_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    mid_q      <= mid_d;
    vec_q      <= vec_d;
    ud_q       <= ud_d;
    uv_q       <= uv_d;
    off_q      <= off_d;
    len_q      <= len_d;
    dlen_q     <= dlen_d;
    acc_q      <= acc_d;
    prod_q     <= mul_a * mul_b;
    prod_neg_q <= mul_neg;
    kind_q     <= kind_d;
    px_q       <= px_d;
    py_q       <= py_d;
    pz_q       <= pz_d;
    tu_q       <= tu_d;
    tv_q       <= tv_d;
    pal_q      <= pal_d;
    vn_q       <= vn_d;
    sc_q       <= sc_d;
    last_q     <= last_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign pos_z_o         = pz_q;
  assign tex_u_o         = tu_q;
  assign tex_v_o         = tv_q;
  assign palette_index_o = pal_q;
  assign vertex_number_o = vn_q;
  assign segment_count_o = sc_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

/* hw/rtl/segment_ribbon_quad_expander.sv */
// Top level of the segment ribbon quad expander: config registers and unit wiring.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i / in_ready_o + fields | to block
//   cfg     | cfg_valid_i / cfg_ready_o, index | to block
//   out     | out_valid_o / out_ready_i+fields | from block
//
// A kept segment runs up to nine passes through the 64-step radix-2 divider,
// plus three 32-step square roots, or four when the side vector falls back.
// A finish word runs three divisions, none with an empty batch.
// Reset clears the queue, the sums, the count and the config to defaults.
// The two-entry queue takes words while the back end works or the result
// register waits, until it is full; the config port never stalls.
`timescale 1ns / 1ps
`default_nettype none

module segment_ribbon_quad_expander import srqe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic [2:0]         color_code_i,
  input  logic               rejected_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic               tex_u_o,
  output logic [31:0]        tex_v_o,
  output logic [2:0]         palette_index_o,
  output logic [VN_W-1:0]    vertex_number_o,
  output logic [CNT_W-1:0]   segment_count_o,
  output logic               last_o
);

  cfg_t        cfg_q, cfg_d;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_arg;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAMERA_X:   cfg_d.camera_x   = cfg_data_i;
        CFG_CAMERA_Y:   cfg_d.camera_y   = cfg_data_i;
        CFG_CAMERA_Z:   cfg_d.camera_z   = cfg_data_i;
        CFG_HALF_WIDTH: cfg_d.half_width = cfg_data_i;
        CFG_MIN_LENGTH: cfg_d.min_length = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x   <= 32'd0;
      cfg_q.camera_y   <= 32'd0;
      cfg_q.camera_z   <= 32'd0;
      cfg_q.half_width <= HALF_WIDTH_RST;
      cfg_q.min_length <= MIN_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  srqe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .color_code_i (color_code_i),
    .rejected_i   (rejected_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  srqe_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .arg_i   (sqrt_arg),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  srqe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  srqe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .sqrt_start_o    (sqrt_start),
    .sqrt_arg_o      (sqrt_arg),
    .sqrt_done_i     (sqrt_done),
    .sqrt_root_i     (sqrt_root),
    .div_start_o     (div_start),
    .div_num_o       (div_num),
    .div_den_o       (div_den),
    .div_done_i      (div_done),
    .div_quo_i       (div_quo),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .palette_index_o (palette_index_o),
    .vertex_number_o (vertex_number_o),
    .segment_count_o (segment_count_o),
    .last_o          (last_o)
  );

`ifndef NO_ASSERTIONS
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_SUMMARY) |-> last_o)
    else $error("summary word without last");

  a_vertex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_VERTEX) |-> (segment_count_o == '0))
    else $error("vertex word carries a segment count");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_VERTEX) |-> (last_o == (vertex_number_o[1:0] == 2'd3)))
    else $error("last flag not on the fourth corner");

  a_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (palette_index_o <= COLOR_LAST))
    else $error("palette index out of range");
`endif

endmodule

`default_nettype wire

/* verif/segment_ribbon_quad_expander_chk.sv */
// Checker for the ribbon quad expander: predicts vertex and summary words and compares them.
`timescale 1ns / 1ps

module segment_ribbon_quad_expander_chk import srqe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               op_i,
  input  logic [31:0]        start_x_i,
  input  logic [31:0]        start_y_i,
  input  logic [31:0]        start_z_i,
  input  logic [31:0]        end_x_i,
  input  logic [31:0]        end_y_i,
  input  logic [31:0]        end_z_i,
  input  logic [2:0]         color_code_i,
  input  logic               rejected_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               kind_i,
  input  logic [31:0]        pos_x_i,
  input  logic [31:0]        pos_y_i,
  input  logic [31:0]        pos_z_i,
  input  logic               tex_u_i,
  input  logic [31:0]        tex_v_i,
  input  logic [2:0]         palette_index_i,
  input  logic [VN_W-1:0]    vertex_number_i,
  input  logic [CNT_W-1:0]   segment_count_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct {
    bit                kind;
    bit [31:0]         px;
    bit [31:0]         py;
    bit [31:0]         pz;
    bit                tu;
    bit [31:0]         tv;
    bit [2:0]          pal;
    bit [VN_W-1:0]     vn;
    bit [CNT_W-1:0]    cnt;
    bit                last;
  } ribbon_word_t;

  localparam longint ONE_Q30   = 64'sd1 << 30;
  localparam longint OFF_LIMIT = 64'sd1 << 40;

  ribbon_word_t ribbon_q[$];

  bit [31:0] cam[3];
  bit [31:0] half_w;
  bit [15:0] min_len;
  longint    mid_sum[3];
  int        seg_count;

  function automatic bit [63:0] absval(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic bit [63:0] root64(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // sums of squares wrap at 64 bits, as the fixed-point definition does
  function automatic bit [63:0] span(longint a, longint b, longint c);
    bit [63:0] ma, mb, mc, s;
    ma = absval(a);
    mb = absval(b);
    mc = absval(c);
    s  = ((ma * ma) >> 2) + ((mb * mb) >> 2) + ((mc * mc) >> 2);
    return 64'd2 * root64(s);
  endfunction

  function automatic longint unit_q30(longint c, bit [63:0] len);
    bit [63:0] q;
    q = (absval(c) << 30) / len;
    if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint side_offset(longint s, bit [63:0] slen);
    bit [63:0] q;
    q = (absval(s) * {32'd0, half_w}) / slen;
    if (q > 64'(OFF_LIMIT)) q = 64'(OFF_LIMIT);
    return s < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic push_word(bit kind, longint x, longint y, longint z, bit tu, bit [31:0] tv,
                           bit [2:0] pal, bit [VN_W-1:0] vn, bit [CNT_W-1:0] cnt, bit last);
    ribbon_word_t w;
    w.kind = kind;
    w.px   = clip32(x);
    w.py   = clip32(y);
    w.pz   = clip32(z);
    w.tu   = tu;
    w.tv   = tv;
    w.pal  = pal;
    w.vn   = vn;
    w.cnt  = cnt;
    w.last = last;
    ribbon_q.insert(ribbon_q.size(), w);
  endtask

  task automatic expand_segment(bit op, bit [31:0] sp[3], bit [31:0] ep[3], bit [2:0] col,
                                bit rej);
    longint s[3], e[3], d[3], m[3], u[3], v[3], c[3], o[3], avg[3];
    bit [63:0] len, vlen, slen, thr, tvq;
    bit [2:0]  pal;
    bit [VN_W-1:0] base;
    if (op == OP_FINISH) begin
      for (int i = 0; i < 3; i++) begin
        avg[i] = (seg_count != 0) ? mid_sum[i] / longint'(seg_count) : 0;
        mid_sum[i] = 0;
      end
      push_word(KIND_SUMMARY, avg[0], avg[1], avg[2], 1'b0, 32'd0, COLOR_BLUE, VN_W'(0),
                CNT_W'(seg_count), 1'b1);
      seg_count = 0;
      return;
    end
    if (seg_count >= MAX_SEGMENTS) return;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(sp[i]));
      e[i] = longint'($signed(ep[i]));
      d[i] = e[i] - s[i];
    end
    len = span(d[0], d[1], d[2]);
    if (len <= min_len) return;
    for (int i = 0; i < 3; i++) begin
      u[i] = unit_q30(d[i], len);
      m[i] = (s[i] + e[i]) >>> 1;
      v[i] = longint'($signed(cam[i])) - m[i];
    end
    vlen = span(v[0], v[1], v[2]);
    if (vlen > min_len) begin
      for (int i = 0; i < 3; i++) v[i] = unit_q30(v[i], vlen);
    end else begin
      v[0] = 0;
      v[1] = 0;
      v[2] = ONE_Q30;
    end
    c[0] = (u[1] * v[2] - u[2] * v[1]) >>> 30;
    c[1] = (u[2] * v[0] - u[0] * v[2]) >>> 30;
    c[2] = (u[0] * v[1] - u[1] * v[0]) >>> 30;
    thr  = {48'd0, min_len} << 14;
    slen = span(c[0], c[1], c[2]);
    if (slen <= thr) begin
      // fall back to the flat perpendicular; drop if that is short too
      c[0] = -u[1];
      c[1] = u[0];
      c[2] = 0;
      slen = span(c[0], c[1], c[2]);
      if (slen <= thr) return;
    end
    for (int i = 0; i < 3; i++) o[i] = side_offset(c[i], slen);
    tvq  = len >> 4;
    if (tvq > 64'hFFFF_FFFF) tvq = 64'hFFFF_FFFF;
    pal  = rej ? COLOR_RED : ((col > COLOR_LAST) ? COLOR_BLUE : col);
    base = VN_W'(seg_count * 4);
    push_word(KIND_VERTEX, s[0] - o[0], s[1] - o[1], s[2] - o[2], 1'b0, 32'd0, pal, base,
              CNT_W'(0), 1'b0);
    push_word(KIND_VERTEX, s[0] + o[0], s[1] + o[1], s[2] + o[2], 1'b1, 32'd0, pal,
              VN_W'(base + 1), CNT_W'(0), 1'b0);
    push_word(KIND_VERTEX, e[0] + o[0], e[1] + o[1], e[2] + o[2], 1'b1, tvq[31:0], pal,
              VN_W'(base + 2), CNT_W'(0), 1'b0);
    push_word(KIND_VERTEX, e[0] - o[0], e[1] - o[1], e[2] - o[2], 1'b0, tvq[31:0], pal,
              VN_W'(base + 3), CNT_W'(0), 1'b1);
    for (int i = 0; i < 3; i++) mid_sum[i] += m[i];
    seg_count++;
  endtask

  task automatic report_mismatch(string field, bit [63:0] got, bit [63:0] want);
    $display("[%0t] %s: got %0h, want %0h", $time, field, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ribbon_word_t w;
    bit [31:0] sp[3];
    bit [31:0] ep[3];
    if (!rst_ni) begin
      cam       = '{0, 0, 0};
      half_w    = HALF_WIDTH_RST;
      min_len   = MIN_LENGTH_RST;
      mid_sum   = '{0, 0, 0};
      seg_count = 0;
      errors_o  = 0;
      ribbon_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAMERA_X:   cam[0] = cfg_data_i;
          CFG_CAMERA_Y:   cam[1] = cfg_data_i;
          CFG_CAMERA_Z:   cam[2] = cfg_data_i;
          CFG_HALF_WIDTH: half_w = cfg_data_i;
          CFG_MIN_LENGTH: min_len = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (ribbon_q.size() == 0) begin
          report_mismatch("unexpected word, kind", kind_i, 0);
        end else begin
          w = ribbon_q.pop_front();
          if (kind_i !== w.kind) report_mismatch("kind", kind_i, w.kind);
          if (pos_x_i !== w.px) report_mismatch("pos_x", pos_x_i, w.px);
          if (pos_y_i !== w.py) report_mismatch("pos_y", pos_y_i, w.py);
          if (pos_z_i !== w.pz) report_mismatch("pos_z", pos_z_i, w.pz);
          if (tex_u_i !== w.tu) report_mismatch("tex_u", tex_u_i, w.tu);
          if (tex_v_i !== w.tv) report_mismatch("tex_v", tex_v_i, w.tv);
          if (palette_index_i !== w.pal) report_mismatch("palette", palette_index_i, w.pal);
          if (vertex_number_i !== w.vn) report_mismatch("vertex_number", vertex_number_i, w.vn);
          if (segment_count_i !== w.cnt) report_mismatch("segment_count", segment_count_i, w.cnt);
          if (last_i !== w.last) report_mismatch("last", last_i, w.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        sp = '{start_x_i, start_y_i, start_z_i};
        ep = '{end_x_i, end_y_i, end_z_i};
        expand_segment(op_i, sp, ep, color_code_i, rejected_i);
      end
      pending_o = ribbon_q.size();
    end
  end

endmodule

/* verif/segment_ribbon_quad_expander_tb.sv */
// Testbench top of the ribbon quad expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module segment_ribbon_quad_expander_tb;
  import srqe_pkg::*;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic               op_i = 0;
  logic [31:0]        start_x_i = 0, start_y_i = 0, start_z_i = 0;
  logic [31:0]        end_x_i = 0, end_y_i = 0, end_z_i = 0;
  logic [2:0]         color_code_i = 0;
  logic               rejected_i = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = 0;
  logic [31:0]        cfg_data_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic               kind_o;
  logic [31:0]        pos_x_o, pos_y_o, pos_z_o;
  logic               tex_u_o;
  logic [31:0]        tex_v_o;
  logic [2:0]         palette_index_o;
  logic [VN_W-1:0]    vertex_number_o;
  logic [CNT_W-1:0]   segment_count_o;
  logic               last_o;
  int                 errors;
  int                 pending;

  bit calm = 0;
  bit hold_off_req = 0;

  always #1 clk_i = ~clk_i;

  segment_ribbon_quad_expander u_dut (.*);

  segment_ribbon_quad_expander_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i,
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .color_code_i, .rejected_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .tex_u_i(tex_u_o), .tex_v_i(tex_v_o), .palette_index_i(palette_index_o),
    .vertex_number_i(vertex_number_o), .segment_count_i(segment_count_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  function automatic bit [31:0] q16(int n);
    return 32'(n) << 16;
  endfunction

  task automatic send_word(bit op, bit [31:0] sx, bit [31:0] sy, bit [31:0] sz,
                           bit [31:0] ex, bit [31:0] ey, bit [31:0] ez,
                           bit [2:0] col, bit rej);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    op_i = op;
    start_x_i = sx; start_y_i = sy; start_z_i = sz;
    end_x_i = ex; end_y_i = ey; end_z_i = ez;
    color_code_i = col;
    rejected_i = rej;
    in_valid_i = 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic send_segment(bit [31:0] sx, bit [31:0] sy, bit [31:0] sz,
                              bit [31:0] ex, bit [31:0] ey, bit [31:0] ez);
    send_word(0, sx, sy, sz, ex, ey, ez, 3'($urandom_range(7)), $urandom_range(1));
  endtask

  task automatic send_finish();
    send_word(OP_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              3'($urandom_range(7)), $urandom_range(1));
  endtask

  // drain, let up to three dropped segments still in flight finish, then write
  task automatic write_cfg(bit [31:0] cx, bit [31:0] cy, bit [31:0] cz,
                           bit [31:0] hw, bit [15:0] ml);
    bit [31:0] vals[5];
    vals = '{cx, cy, cz, hw, {16'd0, ml}};
    while (pending != 0) @(negedge clk_i);
    repeat (2500) @(negedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_index_i = 3'(i);
      cfg_data_i  = vals[i];
      cfg_valid_i = 1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      cfg_valid_i = 0;
    end
  endtask

  task automatic random_segment();
    bit [31:0] s[3], e[3];
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1:    begin s[i] = $urandom; e[i] = $urandom; end
        2, 3:    begin s[i] = $urandom; e[i] = s[i] + 32'($urandom_range(6)) - 3; end
        4:       begin s[i] = $urandom; e[i] = s[i]; end
        default: begin
          s[i] = 32'($signed($urandom_range(1 << 23))) - (1 << 22);
          e[i] = 32'($signed($urandom_range(1 << 23))) - (1 << 22);
        end
      endcase
    end
    send_segment(s[0], s[1], s[2], e[0], e[1], e[2]);
  endtask

  // receiver: short random stalls, one long hold-off to back the block up
  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_ready_i = 0;
        repeat (4000) @(negedge clk_i);
      end else if (!calm && $urandom_range(5) == 0) begin
        out_ready_i = 0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end else begin
        out_ready_i = 1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int n;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(negedge clk_i);

    // directed, default config
    send_finish();
    send_word(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd0, 0);
    send_word(0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF,
              3'd1, 0);
    send_word(0, q16(5), q16(5), q16(5), q16(5), q16(5), q16(5), 3'd2, 0);
    send_word(0, 0, 0, 0, 1, 0, 0, 3'd3, 0);
    send_word(0, 0, 0, 0, 2, 0, 0, 3'd4, 0);
    send_word(0, q16(-1), 0, 0, q16(1), 0, 0, 3'd5, 0);
    send_word(0, q16(10), 0, 0, q16(20), 0, 0, 3'd6, 0);
    send_word(0, 0, 0, q16(3), 0, 0, q16(9), 3'd7, 0);
    send_word(0, q16(-4), q16(2), q16(-7), q16(3), q16(-8), q16(1), 3'd1, 1);
    send_word(0, q16(100), q16(-100), q16(7), q16(-100), q16(100), q16(7), 3'd4, 1);
    send_finish();
    send_finish();

    write_cfg(32'h8000_0000, 32'h7FFF_FFFF, q16(3), 32'h0, 16'h0);
    send_word(0, q16(1), q16(2), q16(3), q16(4), q16(-5), q16(6), 3'd3, 0);
    send_word(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 3'd0, 0);
    send_finish();

    write_cfg(0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(0, 0, 0, 0, 32'h1_0000, 0, 0, 3'd1, 0);
    send_word(0, q16(-300), q16(20), q16(40), q16(300), q16(-20), q16(-40), 3'd2, 0);
    send_word(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 3'd4, 1);
    send_finish();

    // random phases over a few camera settings; the first one backs the block up
    for (int p = 0; p < 3; p++) begin
      write_cfg($urandom, $urandom, $urandom, $urandom_range(1 << 20), 16'($urandom_range(64)));
      if (p == 0) hold_off_req = 1;
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(9) == 0) send_finish();
        else random_segment();
      end
      send_finish();
    end

    // fill one batch past its limit; keep the tail free of stalls
    write_cfg(0, 0, 0, HALF_WIDTH_RST, 16'h0);
    for (n = 0; n < 515; n++) begin
      if (n == 460) calm = 1;
      send_segment(32'($urandom_range(1 << 20)), $urandom_range(1 << 20), 0,
                   32'($urandom_range(1 << 20)) + 32'h20_0000, $urandom_range(1 << 20), 7);
    end
    send_finish();

    while (pending != 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/srqe_pkg.sv
hw/rtl/srqe_front.sv
hw/rtl/srqe_sqrt.sv
hw/rtl/srqe_div.sv
hw/rtl/srqe_back.sv
hw/rtl/segment_ribbon_quad_expander.sv
verif/segment_ribbon_quad_expander_chk.sv
verif/segment_ribbon_quad_expander_tb.sv
